@@ hw/rtl/spc_pkg.sv @@
// Shared types and constants for the stack permutation checker.
package spc_pkg;

    // Result operation codes
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_FAIL = 2'd2
    } op_t;

    localparam int unsigned CAP_W = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch a new input beat
        logic emit;       // load the output register
        logic last_beat;  // emitted beat is the final one for this item
        logic push;       // push next incoming train
        logic pop;        // pop the top of the stack
        op_t  op;         // operation of the emitted beat
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic failed;     // sequence already failed
        logic need_push;  // next incoming train not past the target
        logic can_push;   // room on the stack under the capacity
        logic top_match;  // stack not empty and top equals target
        logic out_free;   // output register can take a beat this cycle
    } sts_t;

endpackage

@@ hw/rtl/spc_ctrl.sv @@
// Controller state machine for the stack permutation checker.
module spc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  spc_pkg::sts_t sts,
    output spc_pkg::cmd_t cmd
);
    import spc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_CMP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_PUSH;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.failed)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.last_beat = 1'b1;
                        cmd.op        = OP_FAIL;
                    end
                end
                else if (sts.need_push)
                begin
                    if (sts.can_push)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit = 1'b1;
                            cmd.push = 1'b1;
                            cmd.op   = OP_PUSH;
                        end
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.last_beat = 1'b1;
                        cmd.op        = OP_FAIL;
                    end
                end
                else
                begin
                    // top of stack is read this cycle, compared next
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.last_beat = 1'b1;
                    cmd.pop       = sts.top_match;
                    cmd.op        = sts.top_match ? OP_POP : OP_FAIL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Final beat of an item: take the next beat straight away
        if (cmd.emit && cmd.last_beat)
        begin
            s_tready   = 1'b1;
            cmd.load   = s_tvalid;
            state_next = s_tvalid ? ST_EVAL : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hw/rtl/spc_datapath.sv @@
// Datapath: holding stack memory, sequence counters, capacity register, output register.
module spc_datapath #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned TRAIN_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [spc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic [TRAIN_BITS-1:0]     in_target,
    input  logic                      in_last,
    input  spc_pkg::cmd_t             cmd,
    output spc_pkg::sts_t             sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output spc_pkg::op_t              out_op,
    output logic [TRAIN_BITS-1:0]     out_train,
    output logic                      out_end,
    output logic                      out_ok
);
    import spc_pkg::*;

    localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CMP_W  = CAP_W + 1;

    logic [TRAIN_BITS-1:0] mem [STACK_DEPTH];
    logic [TRAIN_BITS-1:0] rd_data_reg;

    logic [CAP_W-1:0]      cap_reg;
    logic [TRAIN_BITS-1:0] target_reg;
    logic                  last_reg;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [TRAIN_BITS:0]   next_in_reg, next_in_next;
    logic                  failed_reg, failed_next;

    logic                  out_valid_reg, out_valid_next;
    op_t                   out_op_reg;
    logic [TRAIN_BITS-1:0] out_train_reg;
    logic                  out_end_reg;
    logic                  out_ok_reg;

    logic [FILL_W-1:0]     fill_m1;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic                  seq_end;

    assign fill_m1 = fill_reg - FILL_W'(1);
    assign wr_idx  = fill_reg[IDX_W-1:0];
    assign rd_idx  = fill_m1[IDX_W-1:0];
    assign seq_end = cmd.emit && cmd.last_beat && last_reg;

    // Status towards the controller
    always_comb
    begin
        sts.failed    = failed_reg;
        sts.need_push = next_in_reg <= {1'b0, target_reg};
        sts.can_push  = (CMP_W'(fill_reg) < CMP_W'(cap_reg)) &&
                        (CMP_W'(fill_reg) < CMP_W'(STACK_DEPTH));
        sts.top_match = (fill_reg != '0) && (rd_data_reg == target_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Holding stack: one write, one registered read of the top
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[wr_idx] <= next_in_reg[TRAIN_BITS-1:0];
        rd_data_reg <= mem[rd_idx];
    end

    // Sequence state updates
    always_comb
    begin
        fill_next    = fill_reg;
        next_in_next = next_in_reg;
        failed_next  = failed_reg;
        priority if (seq_end)
        begin
            fill_next    = '0;
            next_in_next = (TRAIN_BITS + 1)'(1);
            failed_next  = 1'b0;
        end
        else if (cmd.push)
        begin
            fill_next    = fill_reg + FILL_W'(1);
            next_in_next = next_in_reg + (TRAIN_BITS + 1)'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_m1;
        end
        else if (cmd.emit && cmd.op == OP_FAIL)
        begin
            failed_next = 1'b1;
        end
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            fill_reg      <= '0;
            next_in_reg   <= (TRAIN_BITS + 1)'(1);
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            fill_reg      <= fill_next;
            next_in_reg   <= next_in_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input beat and output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= in_target;
            last_reg   <= in_last;
        end
        if (cmd.emit)
        begin
            out_op_reg  <= cmd.op;
            out_end_reg <= cmd.last_beat;
            out_ok_reg  <= seq_end && (cmd.op != OP_FAIL);
            unique case (cmd.op)
                OP_PUSH: out_train_reg <= next_in_reg[TRAIN_BITS-1:0];
                OP_POP:  out_train_reg <= target_reg;
                default: out_train_reg <= '0;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_op    = out_op_reg;
    assign out_train = out_train_reg;
    assign out_end   = out_end_reg;
    assign out_ok    = out_ok_reg;

endmodule

@@ hw/rtl/stack_permutation_checker_core.sv @@
// Top level of the stack permutation checker: stream ports, controller and datapath.
//
// Each input beat carries a target train number; trains enter in order 1, 2, 3, ...
// through a holding stack of up to STACK_DEPTH entries, limited further by the
// capacity register. For every target the block emits one push beat per train it
// pushes, then a pop beat when the stack top matches, or a fail beat otherwise;
// after a fail, each later target of the sequence gives a single fail beat. Push and
// pop beats go out before the sequence is known to succeed, so a consumer must drop
// them when the sequence ends in fail. tlast on the output marks the final beat of
// each target, tuser marks a successful end of sequence, and an input beat with
// tlast set clears all sequence state afterwards. An item passes through an evaluate
// state that issues the pushes one by one (single write port of the stack memory),
// then a compare state on the registered top of stack read; both wait while the
// output is stalled. The next beat is taken in the cycle its predecessor's final
// result is loaded into the output register.
module stack_permutation_checker_core #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned TRAIN_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // capacity register write
    input  logic                      cfg_we,
    input  logic [spc_pkg::CAP_W-1:0] cfg_wdata,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((TRAIN_BITS+7)/8)*8-1:0] s_tdata,  // target_train
    input  logic                      s_tlast,          // last_in_sequence
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [((TRAIN_BITS+9)/8)*8-1:0] m_tdata,  // operation, train_moved
    output logic                      m_tlast,          // end_of_run
    output logic                      m_tuser           // sequence_done_ok
);
    import spc_pkg::*;

    localparam int unsigned OUT_W = ((TRAIN_BITS + 9) / 8) * 8;
    localparam int unsigned PAD_W = OUT_W - TRAIN_BITS - 2;

    cmd_t                  cmd;
    sts_t                  sts;
    op_t                   out_op;
    logic [TRAIN_BITS-1:0] out_train;

    spc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .TRAIN_BITS  (TRAIN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_target (s_tdata[TRAIN_BITS-1:0]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_op    (out_op),
        .out_train (out_train),
        .out_end   (m_tlast),
        .out_ok    (m_tuser)
    );

    // Pack result beat: operation lowest, then train, zero padding
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, out_train, out_op};
        end
        else
        begin : g_nopad
            assign m_tdata = {out_train, out_op};
        end
    endgenerate

    // Fail beats carry no train
    a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_op == OP_FAIL |-> out_train == '0)
        else $error("fail beat with non-zero train");

    // Successful end of sequence only on a final pop beat
    a_ok_on_pop : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && out_op == OP_POP)
        else $error("sequence_done_ok on a non-final or non-pop beat");

    // A new beat is taken only when the previous item is finished
    a_load_on_final : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && cmd.emit |-> cmd.last_beat)
        else $error("input taken while item still producing results");

    // A push is only commanded when it is needed and there is room
    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.can_push && sts.need_push && !sts.failed)
        else $error("push without room or need");

endmodule

@@ dv/tb_stack_permutation_checker_core.sv @@
// Self-checking testbench for the stack permutation checker core.
module tb_stack_permutation_checker_core;
    import spc_pkg::*;

    localparam int unsigned DEPTH          = 32;
    localparam int unsigned TRAIN_W        = 16;
    localparam int unsigned S_W            = ((TRAIN_W + 7) / 8) * 8;
    localparam int unsigned M_W            = ((TRAIN_W + 9) / 8) * 8;
    localparam int unsigned RANDOM_ITEMS   = 40;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    // One expected result beat
    typedef struct {
        op_t                op;
        logic [TRAIN_W-1:0] train;
        logic               end_run;
        logic               done_ok;
    } train_move_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [S_W-1:0]     s_tdata   = '0;  // target_train
    logic               s_tlast   = 1'b0;  // last_in_sequence
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [M_W-1:0]     m_tdata;  // operation, train_moved
    logic               m_tlast;  // end_of_run
    logic               m_tuser;  // sequence_done_ok

    // Predictor state: holding stack, fill, next train to enter, failure, capacity
    logic [TRAIN_W-1:0] yard_stack [DEPTH];
    int unsigned        yard_fill  = 0;
    logic [16:0]        next_train = 17'd1;
    logic               seq_failed = 1'b0;
    logic [CAP_W-1:0]   yard_cap   = CAP_RESET;

    train_move_t        pending_moves[$];
    int unsigned        mismatches    = 0;
    int unsigned        items_sent    = 0;
    int unsigned        send_idle_pct = 29;
    int unsigned        recv_idle_pct = 49;
    bit                 hold_req      = 1'b0;

    stack_permutation_checker_core #(
        .STACK_DEPTH (DEPTH),
        .TRAIN_BITS  (TRAIN_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Work out the result beats of one target and queue them
    function automatic void predict_moves(input logic [TRAIN_W-1:0] target, input logic last);
        train_move_t moves[$];
        train_move_t mv;
        int unsigned room;
        room = (yard_cap > DEPTH) ? DEPTH : yard_cap;
        mv.end_run = 1'b0;
        mv.done_ok = 1'b0;
        if (!seq_failed)
        begin
            // push incoming trains until the next one is past the target
            while (!seq_failed && next_train <= {1'b0, target})
            begin
                if (yard_fill < room)
                begin
                    yard_stack[yard_fill] = next_train[TRAIN_W-1:0];
                    yard_fill++;
                    mv.op    = OP_PUSH;
                    mv.train = next_train[TRAIN_W-1:0];
                    moves.push_back(mv);
                    next_train = next_train + 17'd1;
                end
                else
                begin
                    seq_failed = 1'b1;
                end
            end
            if (!seq_failed)
            begin
                if (yard_fill != 0 && yard_stack[yard_fill-1] == target)
                begin
                    yard_fill--;
                    mv.op    = OP_POP;
                    mv.train = target;
                    moves.push_back(mv);
                end
                else
                begin
                    seq_failed = 1'b1;
                end
            end
        end
        if (seq_failed)
        begin
            mv.op    = OP_FAIL;
            mv.train = '0;
            moves.push_back(mv);
        end
        moves[moves.size()-1].end_run = 1'b1;
        // end of sequence: report success, then clear
        if (last)
        begin
            moves[moves.size()-1].done_ok = !seq_failed;
            yard_fill  = 0;
            next_train = 17'd1;
            seq_failed = 1'b0;
        end
        foreach (moves[i])
            pending_moves.push_back(moves[i]);
    endfunction

    // Offer one target beat, after a random gap, and predict on acceptance
    task automatic send_target(input logic [TRAIN_W-1:0] target, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= target;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_moves(target, last);
        items_sent++;
    endtask

    // Capacity write, only once every expected beat is out
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        yard_cap  = cap;
    endtask

    // A stack-reachable departure order of trains 1..count, optionally spoilt
    task automatic send_stack_order(input int unsigned count, input int unsigned room,
                                    input bit corrupt);
        logic [TRAIN_W-1:0] order[$];
        logic [TRAIN_W-1:0] pile[$];
        logic [TRAIN_W-1:0] tmp;
        int unsigned        nxt;
        int unsigned        a;
        int unsigned        b;
        nxt = 1;
        while (order.size() < count)
        begin
            if (pile.size() != 0 &&
                (nxt > count || pile.size() >= room || $urandom_range(0, 1) == 1))
                order.push_back(pile.pop_back());
            else
            begin
                pile.push_back(TRAIN_W'(nxt));
                nxt++;
            end
        end
        if (corrupt)
        begin
            a = $urandom_range(0, count - 1);
            b = $urandom_range(0, count - 1);
            if (a == b)
                order[a] = TRAIN_W'($urandom_range(1, count + 2));
            else
            begin
                tmp      = order[a];
                order[a] = order[b];
                order[b] = tmp;
            end
        end
        foreach (order[i])
            send_target(order[i], i == order.size() - 1);
    endtask

    // Plain orders that succeed and one that does not
    task automatic test_simple_orders();
        send_target(16'd1, 1'b1);
        send_target(16'd3, 1'b0);
        send_target(16'd2, 1'b0);
        send_target(16'd1, 1'b1);
        send_target(16'd2, 1'b0);
        send_target(16'd3, 1'b0);
        send_target(16'd1, 1'b1);
        // 3 then 1 leaves 2 on top: fails, and the rest of the run stays failed
        send_target(16'd3, 1'b0);
        send_target(16'd1, 1'b0);
        send_target(16'd2, 1'b1);
    endtask

    // Target zero and targets far beyond what the stack can hold
    task automatic test_odd_targets();
        send_target(16'd0, 1'b1);
        send_target(16'd2, 1'b0);
        send_target(16'd0, 1'b0);
        send_target(16'd1, 1'b1);
        send_target(16'hFFFF, 1'b1);
        send_target(16'h8000, 1'b0);
        send_target(16'h7FFF, 1'b1);
    endtask

    // Capacity extremes and a capacity change part way through a run
    task automatic test_capacity_limits();
        write_capacity(6'd0);
        send_target(16'd1, 1'b1);
        write_capacity(6'd63);
        send_target(16'd33, 1'b1);
        send_target(16'd32, 1'b1);
        write_capacity(6'd1);
        send_target(16'd1, 1'b0);
        send_target(16'd2, 1'b0);
        send_target(16'd3, 1'b1);
        send_target(16'd2, 1'b0);
        send_target(16'd1, 1'b1);
        write_capacity(6'd4);
        send_target(16'd3, 1'b0);
        // two trains still held, so the next push has no room
        write_capacity(6'd2);
        send_target(16'd4, 1'b0);
        send_target(16'd1, 1'b1);
        write_capacity(6'd32);
    endtask

    // Mostly reachable orders, some spoilt ones, some arbitrary targets
    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input logic [CAP_W-1:0] cap, input bit with_hold);
        int unsigned goal;
        int unsigned kind;
        int unsigned room;
        int unsigned len;
        write_capacity(cap);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        room = (cap > DEPTH) ? DEPTH : cap;
        goal = items_sent + RANDOM_ITEMS;
        if (with_hold)
            hold_req = 1'b1;
        while (items_sent < goal)
        begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            if (kind < 70)
                send_stack_order(len, room, 1'b0);
            else if (kind < 85)
                send_stack_order(len, room, 1'b1);
            else
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_target(($urandom_range(0, 1) == 1) ? TRAIN_W'($urandom_range(0, 65535))
                                                          : TRAIN_W'($urandom_range(0, 40)),
                                i == len - 1);
            end
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned held;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result beat with the oldest expected one
    always @(posedge clk)
    begin : result_check
        train_move_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_moves.size() == 0)
            begin
                $error("unexpected result beat: operation %0d train_moved %0d",
                       m_tdata[1:0], m_tdata[TRAIN_W+1:2]);
                mismatches++;
            end
            else
            begin
                want = pending_moves.pop_front();
                if (m_tdata[1:0] !== want.op)
                begin
                    $error("operation: expected %0d, got %0d", want.op, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[TRAIN_W+1:2] !== want.train)
                begin
                    $error("train_moved: expected %0d, got %0d", want.train,
                           m_tdata[TRAIN_W+1:2]);
                    mismatches++;
                end
                if (m_tdata[M_W-1:TRAIN_W+2] !== '0)
                begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[M_W-1:TRAIN_W+2]);
                    mismatches++;
                end
                if (m_tlast !== want.end_run)
                begin
                    $error("end_of_run: expected %0d, got %0d", want.end_run, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.done_ok)
                begin
                    $error("sequence_done_ok: expected %0d, got %0d", want.done_ok, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_simple_orders();
        test_odd_targets();
        test_capacity_limits();
        test_random_traffic(29, 49, CAP_W'($urandom_range(1, 8)), 1'b0);
        test_random_traffic(49, 29, 6'd32, 1'b0);
        test_random_traffic(0, 0, 6'd63, 1'b1);
        s_tvalid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spc_pkg.sv
hw/rtl/spc_ctrl.sv
hw/rtl/spc_datapath.sv
hw/rtl/stack_permutation_checker_core.sv
dv/tb_stack_permutation_checker_core.sv
